[rtl/psp_pkg.sv]
// ============================================================================
// psp_pkg - shared types and constants for the polygon support point block
// Holds the field widths, item codes and sequencer states. It also holds the
// saturating coordinate add that the datapath uses.
// ============================================================================
package psp_pkg;

    // field widths
    localparam int COORD_W   = 32;
    localparam int SLOT_W    = 4;
    localparam int COUNT_W   = 5;
    localparam int KIND_W    = 1;

    // default table depth and register reset
    localparam int                 DEFAULT_MAX_VERTICES = 16;
    localparam logic [COUNT_W-1:0] COUNT_RESET          = 5'd3;

    // beat packing, first field in the lowest bits
    localparam int S_DATA_RAW_W = SLOT_W + 6 * COORD_W;
    localparam int S_DATA_W     = ((S_DATA_RAW_W + 7) / 8) * 8;
    localparam int M_DATA_RAW_W = 2 * COORD_W + SLOT_W;
    localparam int M_DATA_W     = ((M_DATA_RAW_W + 7) / 8) * 8;

    // item kind codes
    localparam logic [KIND_W-1:0] KIND_LOAD  = 1'b0;
    localparam logic [KIND_W-1:0] KIND_QUERY = 1'b1;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_TRANS,
        ST_MUL_X,
        ST_MUL_Y,
        ST_ACC,
        ST_OUT
    } psp_state_t;

    // signed add saturated to the coordinate range
    function automatic logic signed [COORD_W-1:0] sat_add(
        input logic signed [COORD_W-1:0] a,
        input logic signed [COORD_W-1:0] b
    );
        logic [COORD_W:0] s;
        s = {a[COORD_W-1], a} + {b[COORD_W-1], b};
        if (s[COORD_W] != s[COORD_W-1]) begin
            sat_add = s[COORD_W] ? {1'b1, {(COORD_W-1){1'b0}}}
                                 : {1'b0, {(COORD_W-1){1'b1}}};
        end else begin
            sat_add = s[COORD_W-1:0];
        end
    endfunction

endpackage

[rtl/psp_ram.sv]
// ============================================================================
// psp_ram - generic single write port RAM with registered read
// One write and one read address per cycle; read data appears in the cycle
// after the address. Contents are undefined until written.
// ============================================================================
module psp_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/polygon_support_point.sv]
// ============================================================================
// polygon_support_point - 2D support point search over a vertex table
// Loads Q16.16 vertices one beat at a time and answers support queries:
// the translated vertex with the greatest dot product against a direction.
// ============================================================================
//
//  channel   dir  tuser   tdata                                   result
//  s_axis    in   kind    slot, vx, vy, dir_x, dir_y, pos_x, pos_y  -
//  m_axis    out  -       support_x, support_y, support_slot       1 per query
//  cfg       in   -       vertex_count (5 bits, reset 3)           -
//
//  A query steps through FETCH, then TRANS, MUL_X and MUL_Y for each vertex in
//  use, then ACC and OUT: one shared 32x32 multiplier forms the x and y
//  products of each vertex in the successive states MUL_X and MUL_Y.
//  Reset (aresetn low, synchronous) returns the sequencer to idle; the vertex
//  table is not cleared. s_tready is low while a query runs and until its
//  result beat has been taken.
//
module polygon_support_point
    import psp_pkg::*;
#(
    parameter int MAX_VERTICES = DEFAULT_MAX_VERTICES
) (
    input  logic                aclk,
    input  logic                aresetn,
    // configuration
    input  logic                cfg_we,
    input  logic [COUNT_W-1:0]  cfg_wdata,      // vertex_count
    // input stream
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,        // vertex_slot, vertex_x, vertex_y,
                                                // dir_x, dir_y, pos_x, pos_y
    input  logic [KIND_W-1:0]   s_tuser,        // kind
    // result stream
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata         // support_x, support_y, support_slot
);

    localparam int IDX_W   = $clog2(MAX_VERTICES);
    localparam int EXT_W   = IDX_W + COUNT_W + 1;
    localparam int ENTRY_W = 2 * COORD_W;
    localparam int DOT_W   = 2 * COORD_W + 1;

    // input beat fields
    logic [SLOT_W-1:0]         in_slot;
    logic signed [COORD_W-1:0] in_vx, in_vy, in_dx, in_dy, in_px, in_py;

    assign in_slot = s_tdata[SLOT_W-1:0];
    assign in_vx   = s_tdata[SLOT_W + 1*COORD_W - 1 -: COORD_W];
    assign in_vy   = s_tdata[SLOT_W + 2*COORD_W - 1 -: COORD_W];
    assign in_dx   = s_tdata[SLOT_W + 3*COORD_W - 1 -: COORD_W];
    assign in_dy   = s_tdata[SLOT_W + 4*COORD_W - 1 -: COORD_W];
    assign in_px   = s_tdata[SLOT_W + 5*COORD_W - 1 -: COORD_W];
    assign in_py   = s_tdata[SLOT_W + 6*COORD_W - 1 -: COORD_W];

    psp_state_t state_reg, state_next;

    logic [COUNT_W-1:0]        count_reg;
    logic [IDX_W-1:0]          idx_reg, cur_reg, last_reg, best_slot_reg;
    logic                      pend_reg;
    logic signed [COORD_W-1:0] dx_reg, dy_reg, px_reg, py_reg;
    logic signed [COORD_W-1:0] tx_reg, ty_reg, best_x_reg, best_y_reg;
    logic signed [ENTRY_W-1:0] p_reg, q_reg;
    logic signed [DOT_W-1:0]   best_dot_reg;

    logic s_beat, load_beat, query_beat;
    logic trans_en, mulx_en, muly_en, acc_en;

    assign s_beat     = s_tvalid && s_tready;
    assign load_beat  = s_beat && (s_tuser == KIND_LOAD);
    assign query_beat = s_beat && (s_tuser == KIND_QUERY);

    // vertex count register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= COUNT_RESET;
        end else if (cfg_we) begin
            count_reg <= cfg_wdata;
        end
    end

    // vertex table write: slots beyond the table are dropped
    logic [SLOT_W+IDX_W-1:0] slot_ext;
    logic                    tab_we;
    logic [ENTRY_W-1:0]      tab_rdata;

    assign slot_ext = {{IDX_W{1'b0}}, in_slot};
    assign tab_we   = load_beat && (slot_ext < (SLOT_W+IDX_W)'(MAX_VERTICES));

    psp_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_VERTICES)
    ) u_table (
        .clk   (aclk),
        .we    (tab_we),
        .waddr (slot_ext[IDX_W-1:0]),
        .wdata ({in_vy, in_vx}),
        .raddr (idx_reg),
        .rdata (tab_rdata)
    );

    // last index in use, count clamped to 1 .. MAX_VERTICES
    logic [EXT_W-1:0] cnt_ext, cnt_clamp, last_ext;

    always_comb begin
        cnt_ext = {{(EXT_W-COUNT_W){1'b0}}, count_reg};
        if (cnt_ext == '0) begin
            cnt_clamp = EXT_W'(1);
        end else if (cnt_ext > EXT_W'(MAX_VERTICES)) begin
            cnt_clamp = EXT_W'(MAX_VERTICES);
        end else begin
            cnt_clamp = cnt_ext;
        end
        last_ext = cnt_clamp - EXT_W'(1);
    end

    // sequencer: state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            pend_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            pend_reg  <= (state_reg == ST_MUL_Y);
        end
    end

    // sequencer: next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (query_beat) state_next = ST_FETCH;
            ST_FETCH: state_next = ST_TRANS;
            ST_TRANS: state_next = ST_MUL_X;
            ST_MUL_X: state_next = ST_MUL_Y;
            ST_MUL_Y: state_next = (cur_reg == last_reg) ? ST_ACC : ST_TRANS;
            ST_ACC:   state_next = ST_OUT;
            ST_OUT:   if (m_tready) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // sequencer: outputs
    always_comb begin
        s_tready = (state_reg == ST_IDLE);
        m_tvalid = (state_reg == ST_OUT);
        trans_en = (state_reg == ST_TRANS);
        mulx_en  = (state_reg == ST_MUL_X);
        muly_en  = (state_reg == ST_MUL_Y);
        // accumulate the previous vertex while the next one is translated
        acc_en   = (state_reg == ST_ACC) || ((state_reg == ST_TRANS) && pend_reg);
    end

    // shared multiplier: x product then y product
    logic signed [COORD_W-1:0] mul_a, mul_b;
    logic signed [ENTRY_W-1:0] mul_res;

    assign mul_a   = mulx_en ? tx_reg : ty_reg;
    assign mul_b   = mulx_en ? dx_reg : dy_reg;
    // operands sign-extended to the full product width
    assign mul_res = ENTRY_W'(mul_a) * ENTRY_W'(mul_b);

    // exact 65-bit dot product and compare against the best so far
    logic signed [DOT_W-1:0] dot;
    logic                    take;

    assign dot  = $signed({p_reg[ENTRY_W-1], p_reg}) + $signed({q_reg[ENTRY_W-1], q_reg});
    assign take = (cur_reg == '0) || (dot > best_dot_reg);

    // datapath registers
    always_ff @(posedge aclk) begin
        if (query_beat) begin
            dx_reg   <= in_dx;
            dy_reg   <= in_dy;
            px_reg   <= in_px;
            py_reg   <= in_py;
            last_reg <= last_ext[IDX_W-1:0];
            idx_reg  <= '0;
        end
        if (trans_en) begin
            tx_reg  <= sat_add(tab_rdata[COORD_W-1:0], px_reg);
            ty_reg  <= sat_add(tab_rdata[ENTRY_W-1:COORD_W], py_reg);
            cur_reg <= idx_reg;
            idx_reg <= idx_reg + IDX_W'(1);
        end
        if (mulx_en) begin
            p_reg <= mul_res;
        end
        if (muly_en) begin
            q_reg <= mul_res;
        end
        if (acc_en && take) begin
            best_dot_reg  <= dot;
            best_x_reg    <= tx_reg;
            best_y_reg    <= ty_reg;
            best_slot_reg <= cur_reg;
        end
    end

    // result beat
    logic [SLOT_W+IDX_W-1:0] best_slot_ext;

    assign best_slot_ext = {{SLOT_W{1'b0}}, best_slot_reg};
    assign m_tdata = {{(M_DATA_W-M_DATA_RAW_W){1'b0}},
                      best_slot_ext[SLOT_W-1:0], best_y_reg, best_x_reg};

endmodule
